FILE: rtl/atapio_pkg.sv
// Shared types and constants of the ATA PIO task-file disk device.
package atapio_pkg;

    // Sector geometry and default media size.
    localparam int SECTOR_WORDS      = 256;
    localparam int WORD_W            = $clog2(SECTOR_WORDS);
    localparam int DEF_MEDIA_SECTORS = 64;

    // Configuration register layout.
    localparam int  CFG_ADDR_W        = 3;
    localparam int  LIMIT_W           = 7;
    localparam logic REG_SECTOR_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Command codes.
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;

    // Status and error bits.
    localparam logic [7:0] ST_DRQ   = 8'h08;
    localparam logic [7:0] ST_ERR   = 8'h01;
    localparam logic [7:0] ERR_ABRT = 8'h04;

    // Drive/head reset nibble.
    localparam logic [3:0] HEAD_RESET = 4'hE;

    // Bus access kinds.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Task-file register offsets.
    typedef enum logic [2:0] {
        OFF_DATA    = 3'd0,
        OFF_ERROR   = 3'd1,
        OFF_COUNT   = 3'd2,
        OFF_LBA_LO  = 3'd3,
        OFF_LBA_MID = 3'd4,
        OFF_LBA_HI  = 3'd5,
        OFF_DEVICE  = 3'd6,
        OFF_COMMAND = 3'd7
    } offset_t;

    // Access request to the media memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

FILE: rtl/ata_pio_disk_device.sv
// Top level of the ATA PIO task-file disk device (LBA28, single-sector PIO).
//
//   channel   direction  handshake            payload
//   in        to block   in_valid / in_stall  func, reg_offset, write_data
//   out       from block out_valid/out_stall  read_data
//   config    to block   APB write/read       sector_limit at byte address 0
//
// Each item's result is registered at the accepting edge, and a data-port
// read takes the word from the registered media memory read port. A new item
// is taken in the same cycle that a waiting result leaves, so one item per
// cycle is sustained while out_stall is low and the media sweep is done.
// After reset the media memory is swept to zero, from address zero to the top,
// while in_stall stays high. A stalled result holds until it is taken.
module ata_pio_disk_device #(
    parameter int MEDIA_SECTORS = atapio_pkg::DEF_MEDIA_SECTORS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [atapio_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Bus access items
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [2:0]                       reg_offset,
    input  logic [15:0]                      write_data,
    // Results
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [15:0]                      read_data
);
    import atapio_pkg::*;

    localparam int DEPTH = MEDIA_SECTORS * SECTOR_WORDS;
    localparam int AW    = $clog2(DEPTH);

    // Task-file state.
    logic [LIMIT_W-1:0] limit_reg;
    logic [7:0]         features_reg, features_next;
    logic [7:0]         count_reg, count_next;
    logic [27:0]        lba_reg, lba_next;
    logic [3:0]         head_reg, head_next;
    logic [7:0]         err_byte_reg, err_byte_next;
    logic               err_reg, err_next;
    logic               drq_reg, drq_next;
    logic               xfer_wr_reg, xfer_wr_next;
    logic [WORD_W-1:0]  word_pos_reg, word_pos_next;

    // Output stage.
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        res_reg, res_next;
    logic               from_mem_reg, from_mem_next;

    logic               accept;
    logic               media_busy;
    logic [15:0]        media_rdata;
    mem_cmd_t           mem_cmd;
    logic [AW-1:0]      mem_addr;
    logic [WORD_W+27:0] mem_index;
    logic [7:0]         wbyte;
    logic               lba_bad;
    offset_t            off;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SECTOR_LIMIT) ? {{(32-LIMIT_W){1'b0}}, limit_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_SECTOR_LIMIT))
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Handshakes: a new item is taken once the media sweep is done and the result slot is free or leaving.
    assign in_stall  = media_busy | (out_valid_reg & out_stall);
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign read_data = from_mem_reg ? media_rdata : res_reg;

    // Media address: sector number on top of the word position.
    assign mem_index = {lba_reg, word_pos_reg};
    assign mem_addr  = mem_index[AW-1:0];
    assign off       = offset_t'(reg_offset);
    assign wbyte     = write_data[7:0];

    // Address check against the smaller of the register limit and the media size.
    assign lba_bad = (lba_reg >= {{(28-LIMIT_W){1'b0}}, limit_reg})
                  || (lba_reg >= 28'(MEDIA_SECTORS));

    always_comb
    begin
        mem_cmd.wr_en = accept && (func == FUNC_WRITE) && (off == OFF_DATA)
                        && drq_reg && xfer_wr_reg;
        mem_cmd.rd_en = accept && (func == FUNC_READ) && (off == OFF_DATA)
                        && drq_reg && !xfer_wr_reg;
    end

    // Next state of the task file and the result of one access.
    always_comb
    begin
        features_next = features_reg;
        count_next    = count_reg;
        lba_next      = lba_reg;
        head_next     = head_reg;
        err_byte_next = err_byte_reg;
        err_next      = err_reg;
        drq_next      = drq_reg;
        xfer_wr_next  = xfer_wr_reg;
        word_pos_next = word_pos_reg;
        res_next      = 16'h0000;
        from_mem_next = 1'b0;

        // A data word moved in either direction advances the transfer.
        if (mem_cmd.wr_en || mem_cmd.rd_en)
        begin
            word_pos_next = word_pos_reg + 1'b1;
            if (word_pos_reg == WORD_W'(SECTOR_WORDS - 1))
            begin
                drq_next = 1'b0;
            end
        end

        if (func == FUNC_READ)
        begin
            unique case (off)
                OFF_DATA:    from_mem_next = mem_cmd.rd_en;
                OFF_ERROR:   res_next = {8'h00, err_byte_reg};
                OFF_COUNT:   res_next = {8'h00, count_reg};
                OFF_LBA_LO:  res_next = {8'h00, lba_reg[7:0]};
                OFF_LBA_MID: res_next = {8'h00, lba_reg[15:8]};
                OFF_LBA_HI:  res_next = {8'h00, lba_reg[23:16]};
                OFF_DEVICE:  res_next = {8'h00, head_reg, lba_reg[27:24]};
                OFF_COMMAND: res_next = {8'h00, (drq_reg ? ST_DRQ : 8'h00)
                                              | (err_reg ? ST_ERR : 8'h00)};
                default:     res_next = 16'h0000;
            endcase
        end
        else if (off == OFF_COMMAND)
        begin
            // Any command abandons an open transfer and clears the error.
            err_byte_next = 8'h00;
            err_next      = 1'b0;
            drq_next      = 1'b0;
            word_pos_next = '0;
            if ((wbyte == CMD_READ) || (wbyte == CMD_WRITE))
            begin
                if (lba_bad)
                begin
                    err_next      = 1'b1;
                    err_byte_next = ERR_ABRT;
                end
                else
                begin
                    drq_next     = 1'b1;
                    xfer_wr_next = (wbyte == CMD_WRITE);
                end
            end
            else if (wbyte != CMD_FLUSH)
            begin
                err_next      = 1'b1;
                err_byte_next = ERR_ABRT;
            end
        end
        else if (!drq_reg)
        begin
            // Task-file writes are ignored while a transfer is open.
            unique case (off)
                OFF_ERROR:   features_next = wbyte;
                OFF_COUNT:   count_next = wbyte;
                OFF_LBA_LO:  lba_next[7:0] = wbyte;
                OFF_LBA_MID: lba_next[15:8] = wbyte;
                OFF_LBA_HI:  lba_next[23:16] = wbyte;
                OFF_DEVICE:
                begin
                    head_next       = wbyte[7:4];
                    lba_next[27:24] = wbyte[3:0];
                end
                default:     features_next = features_reg;
            endcase
        end
    end

    // Result slot: loaded on accept, emptied when taken.
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            features_reg  <= 8'h00;
            count_reg     <= 8'h00;
            lba_reg       <= 28'h0;
            head_reg      <= HEAD_RESET;
            err_byte_reg  <= 8'h00;
            err_reg       <= 1'b0;
            drq_reg       <= 1'b0;
            xfer_wr_reg   <= 1'b0;
            word_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
            from_mem_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                features_reg <= features_next;
                count_reg    <= count_next;
                lba_reg      <= lba_next;
                head_reg     <= head_next;
                err_byte_reg <= err_byte_next;
                err_reg      <= err_next;
                drq_reg      <= drq_next;
                xfer_wr_reg  <= xfer_wr_next;
                word_pos_reg <= word_pos_next;
                from_mem_reg <= from_mem_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // Media memory.
    atapio_media #(
        .MEDIA_SECTORS (MEDIA_SECTORS)
    ) u_media (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (write_data),
        .rdata (media_rdata),
        .busy  (media_busy)
    );

    // An open transfer always addresses a sector that exists.
    a_drq_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        drq_reg |-> (lba_reg < 28'(MEDIA_SECTORS)))
        else $error("transfer open on a sector beyond the media");

    // A transfer never opens together with an error.
    a_drq_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(drq_reg && err_reg))
        else $error("DRQ and ERR set together");

    // The error flag and the abort code move together.
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg == (err_byte_reg == ERR_ABRT))
        else $error("error flag and error byte disagree");

    // A media read yields a result taken from the read port in the next cycle.
    a_mem_result: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.rd_en |=> (out_valid_reg && from_mem_reg))
        else $error("media read without a pending memory result");

    // No media access while the clearing sweep runs.
    a_no_access_clear: assert property (@(posedge clk) disable iff (!rst_n)
        media_busy |-> !(mem_cmd.wr_en || mem_cmd.rd_en))
        else $error("media access during the clearing sweep");

endmodule

FILE: rtl/atapio_media.sv
// Media sector memory with a clearing pass after reset.
module atapio_media #(
    parameter int MEDIA_SECTORS = atapio_pkg::DEF_MEDIA_SECTORS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  atapio_pkg::mem_cmd_t      cmd,
    input  logic [$clog2(MEDIA_SECTORS*atapio_pkg::SECTOR_WORDS)-1:0] addr,
    input  logic [15:0]               wdata,
    output logic [15:0]               rdata,
    output logic                      busy
);
    import atapio_pkg::*;

    localparam int DEPTH = MEDIA_SECTORS * SECTOR_WORDS;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0]   mem [DEPTH];
    logic [15:0]   rdata_reg;
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    // Clearing sweep: one word per cycle from address zero to the top.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // The sweep owns the write port while it runs.
    always_comb
    begin
        wr_en   = clearing_reg | cmd.wr_en;
        wr_addr = clearing_reg ? clr_addr_reg : addr;
        wr_data = clearing_reg ? 16'h0000 : wdata;
    end

    // Single-port storage with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

FILE: dv/ata_pio_disk_device_checker.sv
// Checker for the ATA PIO disk device: predicts each item's read data and compares results.
`timescale 1ns / 1ps

module ata_pio_disk_device_checker #(
    parameter int MEDIA_SECTORS = atapio_pkg::DEF_MEDIA_SECTORS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [atapio_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              pready,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              func,
    input  logic [2:0]                        reg_offset,
    input  logic [15:0]                       write_data,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [15:0]                       read_data,
    output int                                mismatch_count,
    output int                                outstanding_reads
);
    import atapio_pkg::*;

    localparam int MEDIA_WORDS = MEDIA_SECTORS * SECTOR_WORDS;
    localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = CFG_ADDR_W'(4 * int'(REG_SECTOR_LIMIT));

    // Shadow copy of the task file, the transfer state and the media.
    logic [LIMIT_W-1:0] sector_limit_q;
    logic [7:0]         features_q;
    logic [7:0]         count_q;
    logic [27:0]        lba_q;
    logic [3:0]         head_q;
    logic [7:0]         error_q;
    logic               err_flag_q;
    logic               drq_q;
    logic               xfer_write_q;
    logic [8:0]         word_pos_q;
    logic [15:0]        media [MEDIA_WORDS];

    logic [15:0] expected_read_data [$];
    int          result_count;

    // The sector limit in force is capped by the size of the media.
    function automatic int limit_in_force();
        return (int'(sector_limit_q) > MEDIA_SECTORS) ? MEDIA_SECTORS : int'(sector_limit_q);
    endfunction

    // Word address of the current transfer position; wraps to zero past the media.
    function automatic logic [31:0] media_word_addr();
        logic [31:0] addr;
        addr = 32'(lba_q) * 32'(SECTOR_WORDS) + 32'(word_pos_q);
        if (addr >= 32'(MEDIA_WORDS))
            addr = '0;
        return addr;
    endfunction

    // Move to the next word; DRQ drops once the whole sector has moved.
    task automatic step_word();
        word_pos_q = word_pos_q + 9'd1;
        if (word_pos_q >= 9'(SECTOR_WORDS))
        begin
            word_pos_q = '0;
            drq_q      = 1'b0;
        end
    endtask

    // Command register write: every command first clears error and transfer state.
    task automatic issue_command(input logic [7:0] cmd);
        error_q    = '0;
        err_flag_q = 1'b0;
        drq_q      = 1'b0;
        word_pos_q = '0;
        if (cmd == CMD_READ || cmd == CMD_WRITE)
        begin
            if (int'(lba_q) >= limit_in_force())
            begin
                err_flag_q = 1'b1;
                error_q    = ERR_ABRT;
            end
            else
            begin
                drq_q        = 1'b1;
                xfer_write_q = (cmd == CMD_WRITE);
            end
        end
        else if (cmd != CMD_FLUSH)
        begin
            err_flag_q = 1'b1;
            error_q    = ERR_ABRT;
        end
    endtask

    // Apply one bus access to the shadow state and return the data it reads.
    task automatic apply_access(input logic f, input offset_t off, input logic [15:0] wd,
                                output logic [15:0] rd);
        logic [7:0] b;
        b  = wd[7:0];
        rd = '0;
        if (f == FUNC_READ)
        begin
            case (off)
                OFF_DATA:
                begin
                    if (drq_q && !xfer_write_q)
                    begin
                        rd = media[media_word_addr()];
                        step_word();
                    end
                end
                OFF_ERROR:   rd = 16'(error_q);
                OFF_COUNT:   rd = 16'(count_q);
                OFF_LBA_LO:  rd = 16'(lba_q[7:0]);
                OFF_LBA_MID: rd = 16'(lba_q[15:8]);
                OFF_LBA_HI:  rd = 16'(lba_q[23:16]);
                OFF_DEVICE:  rd = 16'({head_q, lba_q[27:24]});
                default:     rd = 16'((drq_q ? ST_DRQ : 8'h00) | (err_flag_q ? ST_ERR : 8'h00));
            endcase
        end
        else if (off == OFF_DATA)
        begin
            if (drq_q && xfer_write_q)
            begin
                media[media_word_addr()] = wd;
                step_word();
            end
        end
        else if (off == OFF_COMMAND)
        begin
            issue_command(b);
        end
        else if (!drq_q)
        begin
            // Task-file registers only take writes while no transfer is open.
            case (off)
                OFF_ERROR:   features_q      = b;
                OFF_COUNT:   count_q         = b;
                OFF_LBA_LO:  lba_q[7:0]      = b;
                OFF_LBA_MID: lba_q[15:8]     = b;
                OFF_LBA_HI:  lba_q[23:16]    = b;
                default:
                begin
                    head_q       = b[7:4];
                    lba_q[27:24] = b[3:0];
                end
            endcase
        end
    endtask

    // Watch the configuration port and both item channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] predicted;
        logic [15:0] oldest;
        if (!rst_n)
        begin
            sector_limit_q = LIMIT_RESET;
            features_q     = '0;
            count_q        = '0;
            lba_q          = '0;
            head_q         = HEAD_RESET;
            error_q        = '0;
            err_flag_q     = 1'b0;
            drq_q          = 1'b0;
            xfer_write_q   = 1'b0;
            word_pos_q     = '0;
            for (int i = 0; i < MEDIA_WORDS; i++)
                media[i] = '0;
            expected_read_data.delete();
            result_count      = 0;
            mismatch_count    = 0;
            outstanding_reads = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
                sector_limit_q = pwdata[LIMIT_W-1:0];

            if (in_valid && !in_stall)
            begin
                apply_access(func, offset_t'(reg_offset), write_data, predicted);
                expected_read_data.push_back(predicted);
            end

            if (out_valid && !out_stall)
            begin
                if (expected_read_data.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result %0d arrived with no item outstanding, read_data %h",
                                 $realtime, result_count, read_data);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_read_data.pop_front();
                    if (read_data !== oldest)
                    begin
                        if (mismatch_count < 10)
                            $display("%0t: result %0d read_data mismatch: expected %h, got %h",
                                     $realtime, result_count, oldest, read_data);
                        mismatch_count++;
                    end
                end
                result_count++;
            end

            outstanding_reads = expected_read_data.size();
        end
    end

endmodule

FILE: dv/ata_pio_disk_device_tb.sv
// Testbench top for the ATA PIO disk device: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ata_pio_disk_device_tb;
    import atapio_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = CFG_ADDR_W'(4 * int'(REG_SECTOR_LIMIT));
    localparam logic [7:0] CMD_UNKNOWN = 8'h00;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        func       = FUNC_READ;
    logic [2:0]  reg_offset = OFF_DATA;
    logic [15:0] write_data = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [15:0] read_data;

    int mismatch_count;
    int outstanding_reads;

    // Stimulus bookkeeping.
    int items_sent = 0;
    int cur_limit  = LIMIT_RESET;
    bit quiet      = 1'b0;

    ata_pio_disk_device dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data)
    );

    ata_pio_disk_device_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .reg_offset        (reg_offset),
        .write_data        (write_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .read_data         (read_data),
        .mismatch_count    (mismatch_count),
        .outstanding_reads (outstanding_reads)
    );

    // Clock.
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // The result side stalls at random outside the quiet stretch.
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 12);

    // Hard limit on the run.
    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("DONE: errors detected");
        $finish;
    end

    // Present one item, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_item(input logic f, input offset_t off, input logic [15:0] wd);
        while (!quiet && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        reg_offset <= off;
        write_data <= wd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Stop sending until every outstanding result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding_reads != 0);
    endtask

    // Two-phase APB write of the sector limit; random upper bits must be ignored.
    task automatic write_sector_limit(input int value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {25'($urandom), 7'(value)};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_limit = value;
    endtask

    // Random byte in the upper half, given byte in the lower half.
    function automatic logic [15:0] with_noise(input logic [7:0] b);
        return {8'($urandom), b};
    endfunction

    // Register extremes, error paths and the edges of a transfer.
    task automatic run_directed();
        send_item(FUNC_READ,  OFF_COMMAND, 16'h0000);
        send_item(FUNC_READ,  OFF_DEVICE,  16'hFFFF);
        send_item(FUNC_WRITE, OFF_ERROR,   16'hFFFF);
        send_item(FUNC_WRITE, OFF_COUNT,   16'h00FF);
        send_item(FUNC_READ,  OFF_COUNT,   16'h0000);
        send_item(FUNC_WRITE, OFF_LBA_LO,  16'hFFFF);
        send_item(FUNC_WRITE, OFF_LBA_MID, 16'hFFFF);
        send_item(FUNC_WRITE, OFF_LBA_HI,  16'hFFFF);
        send_item(FUNC_WRITE, OFF_DEVICE,  16'h00FF);
        send_item(FUNC_READ,  OFF_LBA_HI,  16'h0000);
        send_item(FUNC_READ,  OFF_DEVICE,  16'h0000);
        // Read command beyond the limit aborts.
        send_item(FUNC_WRITE, OFF_COMMAND, 16'(CMD_READ));
        send_item(FUNC_READ,  OFF_COMMAND, 16'h0000);
        send_item(FUNC_READ,  OFF_ERROR,   16'h0000);
        send_item(FUNC_WRITE, OFF_COMMAND, 16'(CMD_UNKNOWN));
        send_item(FUNC_WRITE, OFF_COMMAND, 16'hFF00 | 16'(CMD_FLUSH));
        send_item(FUNC_READ,  OFF_COMMAND, 16'h0000);
        // Last sector of the media; data port outside a transfer.
        send_item(FUNC_WRITE, OFF_DEVICE,  16'h00E0);
        send_item(FUNC_WRITE, OFF_LBA_HI,  16'h0000);
        send_item(FUNC_WRITE, OFF_LBA_MID, 16'h0000);
        send_item(FUNC_WRITE, OFF_LBA_LO,  16'(cur_limit - 1));
        send_item(FUNC_WRITE, OFF_DATA,    16'hFFFF);
        send_item(FUNC_READ,  OFF_DATA,    16'h0000);
        // Open a write; task-file writes are ignored while DRQ is set.
        send_item(FUNC_WRITE, OFF_COMMAND, 16'(CMD_WRITE));
        send_item(FUNC_READ,  OFF_COMMAND, 16'h0000);
        send_item(FUNC_WRITE, OFF_LBA_LO,  16'h0000);
        send_item(FUNC_WRITE, OFF_DATA,    16'hFFFF);
        send_item(FUNC_READ,  OFF_LBA_LO,  16'h0000);
    endtask

    // One command sequence: set the address, issue a command, move some data words.
    task automatic run_sector_sequence();
        logic [27:0] lba;
        logic [7:0]  cmd;
        logic        dir;
        int          lim;
        int          pick;
        int          nwords;
        int          roll;

        lim  = (cur_limit > DEF_MEDIA_SECTORS) ? DEF_MEDIA_SECTORS : cur_limit;
        pick = $urandom_range(99);

        // Noise: arbitrary accesses, command writes with random bytes among them.
        if (pick < 8)
        begin
            repeat ($urandom_range(4, 10))
                send_item(1'($urandom), offset_t'($urandom_range(7)), 16'($urandom));
            return;
        end

        // Often a few low sectors so that data read back was written earlier.
        pick = $urandom_range(99);
        if (lim > 0 && pick < 45)
            lba = 28'($urandom_range((lim < 4 ? lim : 4) - 1));
        else if (lim > 0 && pick < 85)
            lba = 28'($urandom_range(lim - 1));
        else if (pick < 93)
            lba = 28'($urandom_range(127, lim));
        else
            lba = 28'($urandom);

        // Close any open transfer first, except in a few broken sequences.
        if ($urandom_range(99) < 80)
            send_item(FUNC_WRITE, OFF_COMMAND, with_noise(CMD_FLUSH));
        if ($urandom_range(99) < 25)
            send_item(FUNC_WRITE, OFF_COUNT, 16'($urandom));
        if ($urandom_range(99) < 15)
            send_item(FUNC_WRITE, OFF_ERROR, 16'($urandom));
        send_item(FUNC_WRITE, OFF_LBA_LO,  with_noise(lba[7:0]));
        send_item(FUNC_WRITE, OFF_LBA_MID, with_noise(lba[15:8]));
        send_item(FUNC_WRITE, OFF_LBA_HI,  with_noise(lba[23:16]));
        send_item(FUNC_WRITE, OFF_DEVICE,  with_noise({4'($urandom), lba[27:24]}));

        pick = $urandom_range(99);
        if (pick < 45)
            cmd = CMD_WRITE;
        else if (pick < 85)
            cmd = CMD_READ;
        else if (pick < 90)
            cmd = CMD_FLUSH;
        else
            cmd = 8'($urandom);
        send_item(FUNC_WRITE, OFF_COMMAND, with_noise(cmd));

        if (cmd == CMD_WRITE)
            dir = FUNC_WRITE;
        else if (cmd == CMD_READ)
            dir = FUNC_READ;
        else
            dir = 1'($urandom);

        // Full sectors run a few words past the end to hit the closed data port.
        pick = $urandom_range(99);
        if (pick < 18)
            nwords = SECTOR_WORDS + $urandom_range(3);
        else if (pick < 28)
            nwords = 0;
        else
            nwords = $urandom_range(1, 40);

        for (int k = 0; k < nwords; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 88)
                send_item(dir, OFF_DATA, 16'($urandom));
            else if (roll < 92)
                send_item(!dir, OFF_DATA, 16'($urandom));
            else if (roll < 96)
                send_item(FUNC_READ, OFF_COMMAND, 16'($urandom));
            else
                send_item(1'($urandom), offset_t'($urandom_range(1, 6)), 16'($urandom));
        end

        if ($urandom_range(99) < 30)
        begin
            send_item(FUNC_READ, OFF_COMMAND, 16'($urandom));
            send_item(FUNC_READ, OFF_ERROR, 16'($urandom));
        end

        // Occasionally hold the sender until every result is back.
        if ($urandom_range(99) < 4)
            drain();
    endtask

    task automatic run_phase(input int item_budget);
        int target;
        target = items_sent + item_budget;
        while (items_sent < target)
            run_sector_sequence();
    endtask

    // Main sequence.
    initial
    begin
        int waited;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // The media is cleared after reset while the input side stalls.
        @(negedge clk);
        while (in_stall)
            @(negedge clk);

        write_sector_limit(64);
        run_directed();
        run_phase(280);

        drain();
        write_sector_limit(0);
        run_phase(60);

        drain();
        write_sector_limit(127);
        quiet = 1'b1;
        run_phase(150);
        quiet = 1'b0;
        run_phase(130);

        drain();
        write_sector_limit($urandom_range(1, 63));
        run_phase(230);

        // Wait for the last results, then give stray results a chance to show.
        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (outstanding_reads != 0 && waited < 20000);
        repeat (10) @(negedge clk);

        if (mismatch_count == 0 && outstanding_reads == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
